### rtl/mjpt_pkg.sv
package mjpt_pkg;

    localparam int NUM_JOINTS_DEF = 6;

    localparam int ANGLE_W    = 32;
    localparam int ERR_W      = ANGLE_W + 1;
    localparam int INTEG_W    = 48;
    localparam int TORQUE_W   = 64;
    localparam int JOINT_W    = 3;
    localparam int KP_W       = 14;
    localparam int KI_W       = 2;
    localparam int KD_W       = 18;

    typedef struct packed {
        logic [JOINT_W-1:0]        joint;
        logic signed [ANGLE_W-1:0] target_angle;
        logic signed [ANGLE_W-1:0] measured_angle;
        logic                      fresh;
    } sample_t;

    typedef struct packed {
        logic [JOINT_W-1:0]         joint_out;
        logic signed [TORQUE_W-1:0] torque;
    } torque_t;

    typedef struct packed {
        logic signed [INTEG_W-1:0]  integral_sum;
        logic signed [ERR_W-1:0]    previous_error;
        logic signed [TORQUE_W-1:0] held_torque;
    } joint_state_t;

    localparam int STATE_W = $bits(joint_state_t);

    function automatic logic [KP_W-1:0] kp_of(input logic [JOINT_W-1:0] j);
        logic [KP_W-1:0] k;
        unique case (j)
            3'd0:    k = 14'd10000;
            3'd1:    k = 14'd15000;
            3'd2:    k = 14'd15000;
            3'd3:    k = 14'd2700;
            3'd4:    k = 14'd2700;
            3'd5:    k = 14'd5000;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic [KI_W-1:0] ki_of(input logic [JOINT_W-1:0] j);
        logic [KI_W-1:0] k;
        unique case (j)
            3'd3, 3'd4: k = 2'd1;
            default:    k = 2'd2;
        endcase
        return k;
    endfunction

    function automatic logic [KD_W-1:0] kd_of(input logic [JOINT_W-1:0] j);
        logic [KD_W-1:0] k;
        unique case (j)
            3'd5:    k = 18'd189250;
            default: k = 18'd209250;
        endcase
        return k;
    endfunction

endpackage

### rtl/mjpt_ram.sv
module mjpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/multi_joint_pid_torque_unit.sv
// Per-joint PID torque unit for up to six joints.
// Request channel: sample_valid / sample_ready / sample (joint, target and
// measured angle in signed Q16.16, fresh flag). Response channel:
// torque_valid / torque_ready / torque_cmd (joint index and 64-bit torque).
// Every request yields exactly one response, in order.
// Throughput: one request per cycle, sustained while torque_ready is high. The
// request is registered into the update stage while the state memory read
// shares the accept edge; the PID update then loads the output register.
// Joint state (integral, previous error, held torque) lives in one
// synchronous RAM; a request that follows one for the same joint in the
// next cycle takes the just-written state from a bypass register.
// A fresh request updates the state; a stale one returns the held torque.
// A joint index out of range returns torque zero and leaves state alone.
// Reset clears the per-joint written flags, so all state reads as zero at
// once; no clearing pass is needed and requests are taken right away.
// When torque_ready is low the output holds; an empty update stage still
// takes one request, after which sample_ready drops until space frees.
module multi_joint_pid_torque_unit
    import mjpt_pkg::*;
#(
    parameter int NUM_JOINTS = NUM_JOINTS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_ready,
    input  sample_t sample,
    output logic    torque_valid,
    input  logic    torque_ready,
    output torque_t torque_cmd
);

    localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam logic [JOINT_W-1:0] JOINT_LIMIT = JOINT_W'(NUM_JOINTS);
    localparam logic signed [INTEG_W:0] INTEG_MAX = {2'b00, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W:0] INTEG_MIN = {2'b11, {(INTEG_W-1){1'b0}}};

    logic                    s1_valid_reg;
    logic [JOINT_W-1:0]      s1_joint_reg;
    logic                    s1_fresh_reg;
    logic signed [ERR_W-1:0] s1_err_reg;

    logic                    fwd_valid_reg;
    logic [AW-1:0]           fwd_addr_reg;
    joint_state_t            fwd_data_reg;

    logic [NUM_JOINTS-1:0]   seen_reg;
    logic [NUM_JOINTS-1:0]   seen_next;

    logic                    rsp_valid_reg;
    torque_t                 rsp_reg;
    torque_t                 rsp_next;

    logic                    out_adv;
    logic                    s1_adv;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           s1_addr;
    logic [STATE_W-1:0]      ram_rdata;
    joint_state_t            entry;
    joint_state_t            wr_state;
    logic                    s1_in_range;
    logic                    we;

    logic signed [ERR_W-1:0]     sample_err;
    logic signed [INTEG_W:0]     integ_sum;
    logic signed [INTEG_W-1:0]   integ_sat;
    logic signed [ERR_W:0]       diff;
    logic signed [INTEG_W-1:0]   p_prop;
    logic signed [INTEG_W+2:0]   p_int;
    logic signed [ERR_W+KD_W+1:0] p_der;
    logic signed [TORQUE_W-1:0]  torque_sum;

    assign out_adv      = !rsp_valid_reg || torque_ready;
    assign s1_adv       = !s1_valid_reg || out_adv;
    assign sample_ready = s1_adv;
    assign torque_valid = rsp_valid_reg;
    assign torque_cmd   = rsp_reg;

    assign s1_addr = s1_joint_reg[AW-1:0];
    assign rd_addr = s1_adv ? sample.joint[AW-1:0] : s1_addr;

    assign sample_err = {sample.target_angle[ANGLE_W-1], sample.target_angle}
                      - {sample.measured_angle[ANGLE_W-1], sample.measured_angle};

    mjpt_ram #(
        .WIDTH (STATE_W),
        .DEPTH (NUM_JOINTS),
        .AW    (AW)
    ) u_state_ram (
        .clk   (clk),
        .we    (we),
        .waddr (s1_addr),
        .wdata (wr_state),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign s1_in_range = s1_joint_reg < JOINT_LIMIT;

    always_comb
    begin
        entry = '0;
        if (s1_in_range)
        begin
            if (fwd_valid_reg && fwd_addr_reg == s1_addr)
            begin
                entry = fwd_data_reg;
            end
            else if (seen_reg[s1_addr])
            begin
                entry = joint_state_t'(ram_rdata);
            end
        end
    end

    always_comb
    begin
        integ_sum = {entry.integral_sum[INTEG_W-1], entry.integral_sum}
                  + {{(INTEG_W+1-ERR_W){s1_err_reg[ERR_W-1]}}, s1_err_reg};
        if (integ_sum > INTEG_MAX)
        begin
            integ_sat = INTEG_MAX[INTEG_W-1:0];
        end
        else if (integ_sum < INTEG_MIN)
        begin
            integ_sat = INTEG_MIN[INTEG_W-1:0];
        end
        else
        begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end
        diff = {s1_err_reg[ERR_W-1], s1_err_reg}
             - {entry.previous_error[ERR_W-1], entry.previous_error};
        p_prop = s1_err_reg * $signed({1'b0, kp_of(s1_joint_reg)});
        p_int  = integ_sat * $signed({1'b0, ki_of(s1_joint_reg)});
        p_der  = diff * $signed({1'b0, kd_of(s1_joint_reg)});
        torque_sum = {{(TORQUE_W-INTEG_W){p_prop[INTEG_W-1]}}, p_prop}
                   + {{(TORQUE_W-INTEG_W-3){p_int[INTEG_W+2]}}, p_int}
                   + {{(TORQUE_W-ERR_W-KD_W-2){p_der[ERR_W+KD_W+1]}}, p_der};
    end

    assign we = out_adv && s1_valid_reg && s1_fresh_reg && s1_in_range;

    always_comb
    begin
        wr_state.integral_sum   = integ_sat;
        wr_state.previous_error = s1_err_reg;
        wr_state.held_torque    = torque_sum;
    end

    always_comb
    begin
        seen_next = seen_reg;
        if (we)
        begin
            seen_next[s1_addr] = 1'b1;
        end
    end

    always_comb
    begin
        rsp_next.joint_out = s1_joint_reg;
        if (!s1_in_range)
        begin
            rsp_next.torque = '0;
        end
        else if (s1_fresh_reg)
        begin
            rsp_next.torque = torque_sum;
        end
        else
        begin
            rsp_next.torque = entry.held_torque;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            seen_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= we;
            seen_reg      <= seen_next;
            if (s1_adv)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (out_adv)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_joint_reg <= sample.joint;
            s1_fresh_reg <= sample.fresh;
            s1_err_reg   <= sample_err;
        end
        if (we)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= wr_state;
        end
        if (out_adv && s1_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    a_seen_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        we |=> seen_reg[$past(s1_addr)])
        else $error("written flag not set after state write");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_adv |=> s1_valid_reg && $stable(s1_joint_reg)
                                     && $stable(s1_err_reg))
        else $error("update stage lost its request while stalled");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(s1_valid_reg))
        else $error("response raised without a request in the update stage");

endmodule

### tb/tb.sv
module tb;
    import mjpt_pkg::*;

    localparam longint ACC_MAX = (64'sd1 <<< 47) - 64'sd1;
    localparam longint ACC_MIN = -(64'sd1 <<< 47);
    localparam int WIND_RUN = 40;

    logic    clk;
    logic    rst_n = 1'b0;
    logic    sample_valid = 1'b0;
    logic    sample_ready;
    sample_t sample_req = '0;
    logic    torque_valid;
    logic    torque_ready = 1'b0;
    torque_t torque_cmd;

    longint kp_tbl[6] = '{10000, 15000, 15000, 2700, 2700, 5000};
    longint ki_tbl[6] = '{2, 2, 2, 1, 1, 2};
    longint kd_tbl[6] = '{209250, 209250, 209250, 209250, 209250, 189250};

    longint err_sum[6];
    longint last_err[6];
    longint last_torque[6];

    torque_t pending_torques[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int n_fresh = 0;
    int n_stale = 0;
    int n_bad_joint = 0;
    int n_clamps = 0;
    int n_checked = 0;

    multi_joint_pid_torque_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample_req),
        .torque_valid (torque_valid),
        .torque_ready (torque_ready),
        .torque_cmd   (torque_cmd)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("tb failed");
        $finish;
    end

    function automatic torque_t predict_torque(input sample_t s);
        torque_t r;
        longint err;
        longint acc;
        longint trq;
        int j;
        r.joint_out = s.joint;
        r.torque = '0;
        if (s.joint >= NUM_JOINTS_DEF)
        begin
            n_bad_joint++;
        end
        else if (s.fresh)
        begin
            n_fresh++;
            j = s.joint;
            err = longint'($signed(s.target_angle)) - longint'($signed(s.measured_angle));
            acc = err_sum[j] + err;
            if (acc > ACC_MAX)
            begin
                acc = ACC_MAX;
                n_clamps++;
            end
            else if (acc < ACC_MIN)
            begin
                acc = ACC_MIN;
                n_clamps++;
            end
            trq = err * kp_tbl[j] + acc * ki_tbl[j] + (err - last_err[j]) * kd_tbl[j];
            err_sum[j] = acc;
            last_err[j] = err;
            last_torque[j] = trq;
            r.torque = trq;
        end
        else
        begin
            n_stale++;
            r.torque = last_torque[s.joint];
        end
        return r;
    endfunction

    function automatic sample_t make_sample(input int j, input logic [31:0] tgt,
                                            input logic [31:0] meas, input logic fr);
        sample_t s;
        s.joint = 3'(j);
        s.target_angle = tgt;
        s.measured_angle = meas;
        s.fresh = fr;
        return s;
    endfunction

    function automatic logic [31:0] boundary_angle();
        logic [31:0] a;
        case ($urandom_range(0, 3))
            0:       a = 32'h7FFF_FFFF;
            1:       a = 32'h8000_0000;
            2:       a = 32'h0000_0000;
            default: a = 32'hFFFF_FFFF;
        endcase
        return a;
    endfunction

    function automatic sample_t rand_sample();
        sample_t s;
        if ($urandom_range(0, 9) == 0)
            s.joint = 3'($urandom_range(6, 7));
        else
            s.joint = 3'($urandom_range(0, 5));
        s.fresh = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 3))
            0:
            begin
                s.target_angle = $urandom;
                s.measured_angle = $urandom;
            end
            1:
            begin
                s.target_angle = $urandom;
                s.measured_angle = s.target_angle + $signed(32'($urandom_range(0, 2000)))
                                   - 32'sd1000;
            end
            2:
            begin
                s.target_angle = boundary_angle();
                s.measured_angle = boundary_angle();
            end
            default:
            begin
                s.target_angle = $signed(32'($urandom_range(0, 32'h0010_0000)))
                                 - 32'sh0008_0000;
                s.measured_angle = $signed(32'($urandom_range(0, 32'h0010_0000)))
                                   - 32'sh0008_0000;
            end
        endcase
        return s;
    endfunction

    // Call at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_sample(input sample_t s);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        sample_req <= s;
        sample_valid <= 1'b1;
        do @(posedge clk); while (!sample_ready);
        pending_torques.insert(pending_torques.size(), predict_torque(s));
        @(negedge clk);
    endtask

    task automatic wait_until_idle();
        sample_valid <= 1'b0;
        while (pending_torques.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin : check_results
        torque_t want;
        if (rst_n && torque_valid && torque_ready)
        begin
            n_checked++;
            if (pending_torques.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result joint_out=%0d torque=%0d",
                                          torque_cmd.joint_out, torque_cmd.torque));
            end
            else
            begin
                want = pending_torques.pop_front();
                if (torque_cmd.joint_out !== want.joint_out)
                    report_mismatch($sformatf("joint_out expected %0d got %0d",
                                              want.joint_out, torque_cmd.joint_out));
                if (torque_cmd.torque !== want.torque)
                    report_mismatch($sformatf("torque (joint %0d) expected %0d got %0d",
                                              want.joint_out, want.torque,
                                              torque_cmd.torque));
            end
        end
    end

    always @(negedge clk)
        torque_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    task automatic test_stale_after_reset();
        for (int j = 0; j < NUM_JOINTS_DEF; j++)
            send_sample(make_sample(j, 32'h1234_5678, 32'h8765_4321, 1'b0));
    endtask

    task automatic test_angle_extremes();
        send_sample(make_sample(0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        send_sample(make_sample(0, 32'h0000_0000, 32'h0000_0000, 1'b0));
        send_sample(make_sample(0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        send_sample(make_sample(1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        send_sample(make_sample(1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        send_sample(make_sample(2, 32'h0001_0000, 32'h0001_0000, 1'b1));
        send_sample(make_sample(3, 32'h0001_0000, 32'h0000_0000, 1'b1));
        send_sample(make_sample(4, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1));
        send_sample(make_sample(5, 32'h1234_5678, 32'hEDCB_A987, 1'b1));
        send_sample(make_sample(5, 32'h0000_0000, 32'h0000_0000, 1'b0));
    endtask

    task automatic test_bad_joint();
        send_sample(make_sample(6, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        send_sample(make_sample(7, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        send_sample(make_sample(6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        send_sample(make_sample(7, 32'h0000_0000, 32'h0000_0000, 1'b0));
        send_sample(make_sample(1, 32'h0000_0000, 32'h0000_0000, 1'b0));
    endtask

    // Wind the running sum of two joints far up and down, then reverse it.
    task automatic test_integral_wind();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (WIND_RUN)
            send_sample(make_sample(3, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        send_sample(make_sample(3, 32'h0000_0000, 32'h0000_0000, 1'b0));
        repeat (3)
            send_sample(make_sample(3, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        repeat (WIND_RUN)
            send_sample(make_sample(4, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        repeat (3)
            send_sample(make_sample(4, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        wait_until_idle();
    endtask

    task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_sample(rand_sample());
        wait_until_idle();
    endtask

    initial
    begin
        for (int j = 0; j < 6; j++)
        begin
            err_sum[j] = 0;
            last_err[j] = 0;
            last_torque[j] = 0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_stale_after_reset();
        test_angle_extremes();
        test_bad_joint();
        wait_until_idle();
        test_integral_wind();
        test_random_phase(220, 0, 0);
        test_random_phase(220, 55, 0);
        test_random_phase(220, 0, 55);
        test_random_phase(200, 37, 37);

        repeat (10) @(posedge clk);
        if (pending_torques.size() != 0)
            $display("%0d expected results never arrived", pending_torques.size());
        $display("covered %0d fresh, %0d stale and %0d out-of-range requests, %0d clamp hits",
                 n_fresh, n_stale, n_bad_joint, n_clamps);
        $display("checked %0d results, %0d mismatches", n_checked, mismatch_count);
        if (mismatch_count == 0 && pending_torques.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
